// File: src/bsc_pkg.sv
// Shared types and constants for the byte stuffing codec.
// Used by the front end, queue, sequencer and top level; no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FLAG        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MASKED_FLAG = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MASKED_ESC  = 3'd4;

  localparam logic       MODE_STUFF   = 1'b0;
  localparam logic       MODE_DESTUFF = 1'b1;

  localparam logic [7:0] FLAG_RESET        = 8'd126;
  localparam logic [7:0] ESCAPE_RESET      = 8'd125;
  localparam logic [7:0] MASKED_FLAG_RESET = 8'd94;
  localparam logic [7:0] MASKED_ESC_RESET  = 8'd93;

  // Codec settings as seen by the front end
  typedef struct packed {
    logic       mode;
    logic [7:0] flag_byte;
    logic [7:0] escape_byte;
    logic [7:0] masked_flag_byte;
    logic [7:0] masked_escape_byte;
  } cfg_t;

  // One classified input item: one or two output bytes
  typedef struct packed {
    logic [7:0] first_byte;
    logic       first_bad;
    logic [7:0] second_byte;
    logic       two;
    logic       last;
  } job_t;

endpackage

`default_nettype wire

// File: src/bsc_front.sv
// Front end: accepts input bytes, classifies them and queues output jobs.
// Holds the pending-escape state. Depends on bsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsc_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire bsc_pkg::cfg_t cfg,
  input  wire logic          mode_wr,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    data_byte,
  input  wire logic          last_in,
  input  wire logic          q_full,
  output logic               push,
  output bsc_pkg::job_t      job
);

  logic escape_pending;
  logic escape_pending_next;
  logic emit;
  logic accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && emit;

  always_comb begin
    job                 = '0;
    job.last            = last_in;
    job.first_byte      = data_byte;
    emit                = 1'b0;
    escape_pending_next = escape_pending;
    if (cfg.mode == bsc_pkg::MODE_STUFF) begin
      emit = 1'b1;
      if (data_byte == cfg.flag_byte) begin
        job.two         = 1'b1;
        job.first_byte  = cfg.escape_byte;
        job.second_byte = cfg.masked_flag_byte;
      end else if (data_byte == cfg.escape_byte) begin
        job.two         = 1'b1;
        job.first_byte  = cfg.escape_byte;
        job.second_byte = cfg.masked_escape_byte;
      end
    end else if (escape_pending) begin
      emit                = 1'b1;
      escape_pending_next = 1'b0;
      if (data_byte == cfg.masked_escape_byte) begin
        job.first_byte = cfg.escape_byte;
      end else if (data_byte == cfg.masked_flag_byte) begin
        job.first_byte = cfg.flag_byte;
      end else begin
        // bad escape: pass the held escape, then treat this byte afresh
        job.first_byte = cfg.escape_byte;
        job.first_bad  = 1'b1;
        if (data_byte == cfg.escape_byte && !last_in) begin
          escape_pending_next = 1'b1;
        end else begin
          job.two         = 1'b1;
          job.second_byte = data_byte;
        end
      end
    end else if (data_byte == cfg.escape_byte && !last_in) begin
      escape_pending_next = 1'b1;
    end else begin
      emit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
    end else if (mode_wr) begin
      escape_pending <= 1'b0;
    end else if (accept) begin
      escape_pending <= escape_pending_next;
    end
  end

endmodule

`default_nettype wire

// File: src/bsc_queue.sv
// Short job queue between the front end and the output sequencer.
// Register-based FIFO of bsc_pkg::job_t entries; depends on bsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsc_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire bsc_pkg::job_t push_job,
  input  wire logic          pop,
  output bsc_pkg::job_t      head_job,
  output logic               empty,
  output logic               full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  bsc_pkg::job_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign empty    = (count == '0);
  assign full     = (count == CNT_FULL);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/bsc_back.sv
// Output sequencer: plays out the head job one byte per transfer.
// Marks run_last and block_end; depends on bsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire bsc_pkg::job_t head_job,
  input  wire logic          empty,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               run_last,
  output logic               block_end,
  output logic               bad_escape
);

  logic second;
  logic final_one;
  logic xfer;

  assign out_valid  = !empty;
  assign final_one  = second || !head_job.two;
  assign xfer       = out_valid && out_ready;
  assign pop        = xfer && final_one;
  assign out_byte   = second ? head_job.second_byte : head_job.first_byte;
  assign bad_escape = !second && head_job.first_bad;
  assign run_last   = final_one;
  assign block_end  = final_one && head_job.last;

  // advance to the second byte of a pair, back to the first on pop
  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (xfer) begin
      second <= !final_one;
    end
  end

endmodule

`default_nettype wire

// File: src/byte_stuffing_codec_unit.sv
// Top level of the byte stuffing codec: configuration registers and
// front end, job queue and output sequencer. Depends on bsc_pkg.
//
// Use:
//   Input channel in_valid/in_ready carries data_byte and last_in.
//   Output channel out_valid/out_ready carries out_byte, run_last,
//   block_end and bad_escape. Configuration channel cfg_valid/cfg_ready
//   carries cfg_index and cfg_data; cfg_ready is always high and mode
//   uses bit 0 of cfg_data. Writing mode drops any held escape.
//   Each result is registered in the job queue before it shows on the
//   outputs. An input is taken every cycle while the queue has room;
//   the output sequencer sends one byte per cycle while out_ready is
//   high, so an item that stuffs to two bytes takes two transfers and
//   one that yields one byte takes one. A held escape in destuff mode
//   yields nothing until the next byte arrives.
//   Reset clears the queue and the held escape and loads the default
//   flag 126, escape 125, masked values 94 and 93, stuff mode.
//   When the receiver stalls, the current result holds and the queue
//   of QUEUE_DEPTH jobs fills; in_ready then drops until a job leaves.
`timescale 1ns / 1ps
`default_nettype none

module byte_stuffing_codec_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bsc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]                      cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      data_byte,
  input  wire logic                            last_in,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [7:0]                           out_byte,
  output logic                                 run_last,
  output logic                                 block_end,
  output logic                                 bad_escape
);

  bsc_pkg::cfg_t cfg;
  bsc_pkg::job_t push_job;
  bsc_pkg::job_t head_job;
  logic          cfg_wr;
  logic          mode_wr;
  logic          push;
  logic          pop;
  logic          q_empty;
  logic          q_full;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign mode_wr   = cfg_wr && (cfg_index == bsc_pkg::REG_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode               <= bsc_pkg::MODE_STUFF;
      cfg.flag_byte          <= bsc_pkg::FLAG_RESET;
      cfg.escape_byte        <= bsc_pkg::ESCAPE_RESET;
      cfg.masked_flag_byte   <= bsc_pkg::MASKED_FLAG_RESET;
      cfg.masked_escape_byte <= bsc_pkg::MASKED_ESC_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        bsc_pkg::REG_MODE:        cfg.mode               <= cfg_data[0];
        bsc_pkg::REG_FLAG:        cfg.flag_byte          <= cfg_data;
        bsc_pkg::REG_ESCAPE:      cfg.escape_byte        <= cfg_data;
        bsc_pkg::REG_MASKED_FLAG: cfg.masked_flag_byte   <= cfg_data;
        bsc_pkg::REG_MASKED_ESC:  cfg.masked_escape_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  bsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .mode_wr   (mode_wr),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_in   (last_in),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job)
  );

  bsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  bsc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_job   (head_job),
    .empty      (q_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .block_end  (block_end),
    .bad_escape (bad_escape)
  );

endmodule

`default_nettype wire

// File: src/bsc_checker.sv
// Port-level checks for byte_stuffing_codec_unit, bound to the top level.
// Sees the top-level ports only; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module bsc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       run_last,
  input wire logic       block_end,
  input wire logic       bad_escape
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last)
      && $stable(block_end) && $stable(bad_escape))
    else $error("stalled result changed");

  // the end of a buffer is always the last result of its item
  assert property (@(posedge clk) disable iff (rst)
    out_valid && block_end |-> run_last)
    else $error("block_end without run_last");

  // the second byte of a pair follows the first without a gap
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !run_last |=> out_valid)
    else $error("gap inside a two-byte result");

  // reset empties the output
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result visible after reset");

endmodule

bind byte_stuffing_codec_unit bsc_checker u_bsc_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_byte   (out_byte),
  .run_last   (run_last),
  .block_end  (block_end),
  .bad_escape (bad_escape)
);

`default_nettype wire
